// ===== rtl/core/apbp_pkg.sv =====
// ---------------------------------------------------------------------------
// apbp_pkg: shared definitions for the alarm priority and beep pattern block
// Alarm codes, pattern timing constants and configuration register indexes.
// ---------------------------------------------------------------------------
package apbp_pkg;

    // Alarm codes, in descending priority after NONE.
    typedef enum logic [2:0] {
        ALARM_NONE     = 3'd0,
        ALARM_CRITICAL = 3'd1,
        ALARM_FULL     = 3'd2,
        ALARM_LEAK     = 3'd3,
        ALARM_BLOCK    = 3'd4,
        ALARM_LOW      = 3'd5
    } alarm_code_t;

    // Configuration register indexes (byte address bit 2).
    localparam logic CFG_IDX_MUTE_LIMIT = 1'b0;
    localparam logic CFG_IDX_BEEPER_MAX = 1'b1;

    // Configuration reset values.
    localparam logic [15:0] MUTE_LIMIT_RESET = 16'd15000;
    localparam logic [9:0]  BEEPER_MAX_RESET = 10'd60;

    // Pattern timing, in ticks.
    localparam logic [6:0] LONG_ON_TICKS     = 7'd30;
    localparam logic [6:0] LONG_PERIOD_TICKS = 7'd40;
    localparam logic [6:0] DOUBLE_BEEP_TICKS = 7'd10;
    localparam logic [6:0] DOUBLE_REST_TICKS = 7'd100;
    localparam logic [6:0] LOW_ON_TICKS      = 7'd5;
    localparam logic [6:0] LOW_PERIOD_TICKS  = 7'd100;

    // LED blink timing, in ticks.
    localparam logic [5:0] BLINK_HALF_TICKS   = 6'd25;
    localparam logic [5:0] BLINK_PERIOD_TICKS = 6'd50;

    // Guard limit scale.
    localparam logic [15:0] TICKS_PER_SECOND = 16'd50;

endpackage

// ===== rtl/core/alarm_priority_beep_pattern.sv =====
// ---------------------------------------------------------------------------
// alarm_priority_beep_pattern: alarm selection and buzzer/LED pattern driver
// Picks the highest-priority alarm on each tick beat, advances the buzzer
// pattern, LED blink, mute and guard counters, and returns one result beat.
// ---------------------------------------------------------------------------
// The result of an accepted input beat is registered and shown in the next cycle.
// Throughput: one beat per cycle; the state registers double as the result
// register, and a new beat is taken whenever the result is empty or taken.
// Reset: rst_n clears all pattern, mute and guard state, drops out_valid and
// loads the configuration registers with 15000 ticks and 60 seconds.
module alarm_priority_beep_pattern (
    input  logic        clk,
    input  logic        rst_n,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic        mute_value,
    input  logic [6:0]  battery_level,
    input  logic        charging,
    input  logic        battery_low,
    input  logic        tank_full,
    input  logic        leak_found,
    input  logic        block_found,
    // Result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic        buzzer_on,
    output logic        white_led_on,
    output logic [2:0]  alarm_code,
    output logic        muted,
    output logic        alarm_sounding,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_BEEP1 = 3'd1,
        PH_GAP   = 3'd2,
        PH_BEEP2 = 3'd3,
        PH_REST  = 3'd4
    } phase_t;

    // Configuration registers
    logic [15:0] mute_limit_reg;
    logic [9:0]  beeper_max_reg;

    // Block state, which is also the result held for the output channel
    logic        out_valid_reg;
    logic        buzzer_reg, buzzer_next;
    logic        led_reg, led_next;
    phase_t      phase_reg, phase_next;
    logic [6:0]  pattern_ticks_reg, pattern_ticks_next;
    logic [5:0]  blink_ticks_reg, blink_ticks_next;
    logic        mute_reg, mute_next;
    logic [15:0] mute_ticks_reg, mute_ticks_next;
    logic [15:0] guard_ticks_reg, guard_ticks_next;
    logic        sounding_reg, sounding_next;
    apbp_pkg::alarm_code_t last_code_reg, last_code_next;

    logic                  accept;
    logic                  cfg_write;
    apbp_pkg::alarm_code_t code;
    logic [6:0]            pattern_inc;
    logic [5:0]            blink_inc;
    logic [15:0]           mute_inc;
    logic [15:0]           guard_inc;
    logic [15:0]           guard_limit;
    logic [6:0]            tone_on;
    logic [6:0]            tone_period;

    // Handshake: the result register frees up when it is empty or being taken.
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    assign buzzer_on      = buzzer_reg;
    assign white_led_on   = led_reg;
    assign alarm_code     = last_code_reg;
    assign muted          = mute_reg;
    assign alarm_sounding = sounding_reg;

    // Configuration port: writes complete in the access phase, no wait states.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            apbp_pkg::CFG_IDX_MUTE_LIMIT: prdata = {16'd0, mute_limit_reg};
            apbp_pkg::CFG_IDX_BEEPER_MAX: prdata = {22'd0, beeper_max_reg};
            default:                      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mute_limit_reg <= apbp_pkg::MUTE_LIMIT_RESET;
            beeper_max_reg <= apbp_pkg::BEEPER_MAX_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == apbp_pkg::CFG_IDX_MUTE_LIMIT)
            begin
                mute_limit_reg <= pwdata[15:0];
            end
            else
            begin
                beeper_max_reg <= pwdata[9:0];
            end
        end
    end

    // Fixed-priority alarm selection.
    always_comb
    begin
        priority if (battery_level == 7'd0 && !charging)
        begin
            code = apbp_pkg::ALARM_CRITICAL;
        end
        else if (tank_full)
        begin
            code = apbp_pkg::ALARM_FULL;
        end
        else if (leak_found)
        begin
            code = apbp_pkg::ALARM_LEAK;
        end
        else if (block_found)
        begin
            code = apbp_pkg::ALARM_BLOCK;
        end
        else if (battery_low && !charging)
        begin
            code = apbp_pkg::ALARM_LOW;
        end
        else
        begin
            code = apbp_pkg::ALARM_NONE;
        end
    end

    // Counter increments, wrapping at their widths.
    assign pattern_inc = pattern_ticks_reg + 7'd1;
    assign blink_inc   = blink_ticks_reg + 6'd1;
    assign mute_inc    = mute_ticks_reg + 16'd1;
    assign guard_inc   = guard_ticks_reg + 16'd1;
    assign guard_limit = 16'(beeper_max_reg) * apbp_pkg::TICKS_PER_SECOND;

    // Timed tone shape: long tone for critical and full, slow beep otherwise.
    always_comb
    begin
        if (code == apbp_pkg::ALARM_CRITICAL || code == apbp_pkg::ALARM_FULL)
        begin
            tone_on     = apbp_pkg::LONG_ON_TICKS;
            tone_period = apbp_pkg::LONG_PERIOD_TICKS;
        end
        else
        begin
            tone_on     = apbp_pkg::LOW_ON_TICKS;
            tone_period = apbp_pkg::LOW_PERIOD_TICKS;
        end
    end

    // Next-state logic for one beat.
    always_comb
    begin
        buzzer_next        = buzzer_reg;
        led_next           = led_reg;
        phase_next         = phase_reg;
        pattern_ticks_next = pattern_ticks_reg;
        blink_ticks_next   = blink_ticks_reg;
        mute_next          = mute_reg;
        mute_ticks_next    = mute_ticks_reg;
        guard_ticks_next   = guard_ticks_reg;
        sounding_next      = sounding_reg;
        last_code_next     = last_code_reg;

        if (operation)
        begin
            // Set-mute command: muting restarts the mute count and silences.
            mute_next = mute_value;
            if (mute_value)
            begin
                mute_ticks_next = 16'd0;
                buzzer_next     = 1'b0;
            end
        end
        else
        begin
            last_code_next = code;
            if (code != apbp_pkg::ALARM_NONE)
            begin
                // LED blink: on for the first half period, then off.
                blink_ticks_next = blink_inc;
                if (blink_ticks_reg < apbp_pkg::BLINK_HALF_TICKS)
                begin
                    led_next = 1'b1;
                end
                else if (blink_inc < apbp_pkg::BLINK_PERIOD_TICKS)
                begin
                    led_next = 1'b0;
                end
                else
                begin
                    blink_ticks_next = 6'd0;
                end
                sounding_next = 1'b1;

                if (mute_reg)
                begin
                    buzzer_next = 1'b0;
                end
                else
                begin
                    if (code == apbp_pkg::ALARM_LEAK || code == apbp_pkg::ALARM_BLOCK)
                    begin
                        // Double beep sequence.
                        unique case (phase_reg)
                            PH_IDLE:
                            begin
                                phase_next         = PH_BEEP1;
                                pattern_ticks_next = 7'd0;
                            end
                            PH_BEEP1:
                            begin
                                buzzer_next        = 1'b1;
                                pattern_ticks_next = pattern_inc;
                                if (pattern_ticks_reg >= apbp_pkg::DOUBLE_BEEP_TICKS)
                                begin
                                    phase_next         = PH_GAP;
                                    pattern_ticks_next = 7'd0;
                                end
                            end
                            PH_GAP:
                            begin
                                buzzer_next        = 1'b0;
                                pattern_ticks_next = pattern_inc;
                                if (pattern_ticks_reg >= apbp_pkg::DOUBLE_BEEP_TICKS)
                                begin
                                    phase_next         = PH_BEEP2;
                                    pattern_ticks_next = 7'd0;
                                end
                            end
                            PH_BEEP2:
                            begin
                                buzzer_next        = 1'b1;
                                pattern_ticks_next = pattern_inc;
                                if (pattern_ticks_reg >= apbp_pkg::DOUBLE_BEEP_TICKS)
                                begin
                                    phase_next         = PH_REST;
                                    pattern_ticks_next = 7'd0;
                                end
                            end
                            PH_REST:
                            begin
                                buzzer_next        = 1'b0;
                                pattern_ticks_next = pattern_inc;
                                if (pattern_ticks_reg >= apbp_pkg::DOUBLE_REST_TICKS)
                                begin
                                    phase_next         = PH_IDLE;
                                    pattern_ticks_next = 7'd0;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                    else
                    begin
                        // Timed tone: on for the first part of the period.
                        pattern_ticks_next = pattern_inc;
                        if (pattern_ticks_reg < tone_on)
                        begin
                            buzzer_next = 1'b1;
                        end
                        else if (pattern_inc < tone_period)
                        begin
                            buzzer_next = 1'b0;
                        end
                        else
                        begin
                            pattern_ticks_next = 7'd0;
                        end
                    end

                    // Guard: force the buzzer off once the count passes the limit.
                    guard_ticks_next = guard_inc;
                    if (guard_ticks_reg > guard_limit)
                    begin
                        buzzer_next      = 1'b0;
                        guard_ticks_next = 16'd0;
                    end
                end
            end
            else
            begin
                // No alarm: steady LED, silent buzzer, pattern back to idle.
                led_next      = 1'b1;
                sounding_next = 1'b0;
                buzzer_next   = 1'b0;
                phase_next    = PH_IDLE;
            end

            // Mute expiry count.
            if (mute_reg)
            begin
                mute_ticks_next = mute_inc;
                if (mute_ticks_reg >= mute_limit_reg)
                begin
                    mute_next       = 1'b0;
                    mute_ticks_next = 16'd0;
                end
            end
        end
    end

    // State and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg     <= 1'b0;
            buzzer_reg        <= 1'b0;
            led_reg           <= 1'b0;
            phase_reg         <= PH_IDLE;
            pattern_ticks_reg <= 7'd0;
            blink_ticks_reg   <= 6'd0;
            mute_reg          <= 1'b0;
            mute_ticks_reg    <= 16'd0;
            guard_ticks_reg   <= 16'd0;
            sounding_reg      <= 1'b0;
            last_code_reg     <= apbp_pkg::ALARM_NONE;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg     <= 1'b1;
                buzzer_reg        <= buzzer_next;
                led_reg           <= led_next;
                phase_reg         <= phase_next;
                pattern_ticks_reg <= pattern_ticks_next;
                blink_ticks_reg   <= blink_ticks_next;
                mute_reg          <= mute_next;
                mute_ticks_reg    <= mute_ticks_next;
                guard_ticks_reg   <= guard_ticks_next;
                sounding_reg      <= sounding_next;
                last_code_reg     <= last_code_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

// ===== rtl/core/apbp_checker.sv =====
// ---------------------------------------------------------------------------
// apbp_checker: port-level checks for alarm_priority_beep_pattern
// Watches the result channel for stable stalled beats and consistent alarm
// status, and is bound into alarm_priority_beep_pattern.
// ---------------------------------------------------------------------------
module apbp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic       buzzer_on,
    input logic       white_led_on,
    input logic [2:0] alarm_code,
    input logic       muted,
    input logic       alarm_sounding
);

    // A stalled result beat holds until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(buzzer_on)
            && $stable(white_led_on) && $stable(alarm_code)
            && $stable(muted) && $stable(alarm_sounding))
    else $error("stalled result beat changed");

    // The sounding flag follows whether the last tick selected an alarm.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> alarm_sounding == (alarm_code != apbp_pkg::ALARM_NONE))
    else $error("alarm_sounding disagrees with alarm_code");

    // A muted block never drives the buzzer.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && muted |-> !buzzer_on)
    else $error("buzzer on while muted");

    // Without an alarm the buzzer stays off.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alarm_code == apbp_pkg::ALARM_NONE |-> !buzzer_on)
    else $error("buzzer on with no alarm");

endmodule

bind alarm_priority_beep_pattern apbp_checker u_apbp_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .buzzer_on      (buzzer_on),
    .white_led_on   (white_led_on),
    .alarm_code     (alarm_code),
    .muted          (muted),
    .alarm_sounding (alarm_sounding)
);

// ===== tb/alarm_tb_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// alarm_tb_pkg: beat types and result scoreboard for the alarm pattern bench
// Holds the input and result beat layouts, the bench's own pattern timing,
// and a scoreboard that tracks the alarm, buzzer, LED, mute and guard state
// to predict every result beat and compare it with what the block returns.
// ---------------------------------------------------------------------------
package alarm_tb_pkg;

    // Operation codes carried by an input beat.
    localparam logic OP_TICK     = 1'b0;
    localparam logic OP_SET_MUTE = 1'b1;

    // Pattern and blink timing, in ticks.
    localparam int unsigned LONG_TONE_ON        = 30;
    localparam int unsigned LONG_TONE_PERIOD    = 40;
    localparam int unsigned BEEP_SPAN           = 10;
    localparam int unsigned BEEP_REST           = 100;
    localparam int unsigned LOW_TONE_ON         = 5;
    localparam int unsigned LOW_TONE_PERIOD     = 100;
    localparam int unsigned LED_HALF            = 25;
    localparam int unsigned LED_PERIOD          = 50;
    localparam int unsigned GUARD_TICKS_PER_SEC = 50;

    // Double-beep pattern phases.
    typedef enum logic [2:0] {
        PH_IDLE         = 3'd0,
        PH_FIRST_BEEP   = 3'd1,
        PH_FIRST_PAUSE  = 3'd2,
        PH_SECOND_BEEP  = 3'd3,
        PH_LONG_PAUSE   = 3'd4
    } tone_phase_t;

    typedef struct packed {
        logic       operation;
        logic       mute_value;
        logic [6:0] battery_level;
        logic       charging;
        logic       battery_low;
        logic       tank_full;
        logic       leak_found;
        logic       block_found;
    } tick_beat_t;

    typedef struct packed {
        logic                  buzzer_on;
        logic                  white_led_on;
        apbp_pkg::alarm_code_t alarm_code;
        logic                  muted;
        logic                  alarm_sounding;
    } alarm_result_t;

    class alarm_scoreboard;

        // Configuration copy.
        logic [15:0]   mute_limit;
        logic [9:0]    guard_seconds;

        // Block state as the bench sees it.
        logic                  buzzer;
        logic                  led;
        tone_phase_t           phase;
        logic [6:0]            pattern_count;
        logic [5:0]            blink_count;
        logic                  mute_active;
        logic [15:0]           mute_count;
        logic [15:0]           guard_count;
        logic                  sounding;
        apbp_pkg::alarm_code_t last_alarm;

        alarm_result_t due_results[$];
        int            errors;
        int            checked;

        function new();
            mute_limit    = apbp_pkg::MUTE_LIMIT_RESET;
            guard_seconds = apbp_pkg::BEEPER_MAX_RESET;
            buzzer        = 1'b0;
            led           = 1'b0;
            phase         = PH_IDLE;
            pattern_count = '0;
            blink_count   = '0;
            mute_active   = 1'b0;
            mute_count    = '0;
            guard_count   = '0;
            sounding      = 1'b0;
            last_alarm    = apbp_pkg::ALARM_NONE;
            errors        = 0;
            checked       = 0;
        endfunction

        function void set_register(logic index, logic [31:0] value);
            if (index == apbp_pkg::CFG_IDX_MUTE_LIMIT)
                mute_limit = value[15:0];
            else
                guard_seconds = value[9:0];
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        // Fixed priority; the charger masks both battery alarms.
        function apbp_pkg::alarm_code_t select_alarm(tick_beat_t b);
            if (b.battery_level == 7'd0 && !b.charging)
                return apbp_pkg::ALARM_CRITICAL;
            if (b.tank_full)
                return apbp_pkg::ALARM_FULL;
            if (b.leak_found)
                return apbp_pkg::ALARM_LEAK;
            if (b.block_found)
                return apbp_pkg::ALARM_BLOCK;
            if (b.battery_low && !b.charging)
                return apbp_pkg::ALARM_LOW;
            return apbp_pkg::ALARM_NONE;
        endfunction

        // On for the first on_ticks of the period, then off until it wraps.
        function void step_tone(int unsigned on_ticks, int unsigned period);
            logic [6:0] prior;
            prior = pattern_count;
            pattern_count = prior + 7'd1;
            if (prior < on_ticks)
                buzzer = 1'b1;
            else if (pattern_count < period)
                buzzer = 1'b0;
            else
                pattern_count = '0;
        endfunction

        function void step_phase(logic level, int unsigned span, tone_phase_t next_phase);
            logic [6:0] prior;
            prior = pattern_count;
            buzzer = level;
            pattern_count = prior + 7'd1;
            if (prior >= span)
            begin
                phase = next_phase;
                pattern_count = '0;
            end
        endfunction

        function void step_double_beep();
            unique case (phase)
                PH_IDLE:
                begin
                    phase = PH_FIRST_BEEP;
                    pattern_count = '0;
                end
                PH_FIRST_BEEP:  step_phase(1'b1, BEEP_SPAN, PH_FIRST_PAUSE);
                PH_FIRST_PAUSE: step_phase(1'b0, BEEP_SPAN, PH_SECOND_BEEP);
                PH_SECOND_BEEP: step_phase(1'b1, BEEP_SPAN, PH_LONG_PAUSE);
                PH_LONG_PAUSE:  step_phase(1'b0, BEEP_REST, PH_IDLE);
                default:        phase = PH_IDLE;
            endcase
        endfunction

        // Buzzer pattern for the selected alarm, then the guard limit.
        function void drive_buzzer(apbp_pkg::alarm_code_t code);
            int unsigned guard_limit;
            logic [15:0] prior;
            if (mute_active)
            begin
                buzzer = 1'b0;
                return;
            end
            if (code == apbp_pkg::ALARM_CRITICAL || code == apbp_pkg::ALARM_FULL)
                step_tone(LONG_TONE_ON, LONG_TONE_PERIOD);
            else if (code == apbp_pkg::ALARM_LEAK || code == apbp_pkg::ALARM_BLOCK)
                step_double_beep();
            else
                step_tone(LOW_TONE_ON, LOW_TONE_PERIOD);
            guard_limit = guard_seconds * GUARD_TICKS_PER_SEC;
            prior = guard_count;
            guard_count = prior + 16'd1;
            if (prior > guard_limit)
            begin
                buzzer = 1'b0;
                guard_count = '0;
            end
        endfunction

        // Advance the state by one accepted input beat and queue its result.
        function void note_beat(tick_beat_t b);
            apbp_pkg::alarm_code_t code;
            logic [5:0]            prior_blink;
            logic [15:0]           prior_mute;
            alarm_result_t         due;
            if (b.operation == OP_SET_MUTE)
            begin
                mute_active = b.mute_value;
                if (b.mute_value)
                begin
                    mute_count = '0;
                    buzzer = 1'b0;
                end
            end
            else
            begin
                code = select_alarm(b);
                last_alarm = code;
                if (code != apbp_pkg::ALARM_NONE)
                begin
                    prior_blink = blink_count;
                    blink_count = prior_blink + 6'd1;
                    if (prior_blink < LED_HALF)
                        led = 1'b1;
                    else if (blink_count < LED_PERIOD)
                        led = 1'b0;
                    else
                        blink_count = '0;
                    sounding = 1'b1;
                    drive_buzzer(code);
                end
                else
                begin
                    led = 1'b1;
                    sounding = 1'b0;
                    buzzer = 1'b0;
                    phase = PH_IDLE;
                end
                // Mute runs out once its count has reached the timeout.
                if (mute_active)
                begin
                    prior_mute = mute_count;
                    mute_count = prior_mute + 16'd1;
                    if (prior_mute >= mute_limit)
                    begin
                        mute_active = 1'b0;
                        mute_count = '0;
                    end
                end
            end
            due.buzzer_on      = buzzer;
            due.white_led_on   = led;
            due.alarm_code     = last_alarm;
            due.muted          = mute_active;
            due.alarm_sounding = sounding;
            due_results.push_back(due);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        // Compare one accepted result beat with the oldest prediction.
        task check_result(alarm_result_t got);
            alarm_result_t want;
            if (due_results.size() == 0)
            begin
                report($sformatf("result beat %b with no prediction waiting", got));
                return;
            end
            want = due_results.pop_front();
            checked++;
            if (got.buzzer_on !== want.buzzer_on)
                report($sformatf("result %0d buzzer_on %b, expected %b",
                                 checked, got.buzzer_on, want.buzzer_on));
            if (got.white_led_on !== want.white_led_on)
                report($sformatf("result %0d white_led_on %b, expected %b",
                                 checked, got.white_led_on, want.white_led_on));
            if (got.alarm_code !== want.alarm_code)
                report($sformatf("result %0d alarm_code %0d, expected %0d",
                                 checked, got.alarm_code, want.alarm_code));
            if (got.muted !== want.muted)
                report($sformatf("result %0d muted %b, expected %b",
                                 checked, got.muted, want.muted));
            if (got.alarm_sounding !== want.alarm_sounding)
                report($sformatf("result %0d alarm_sounding %b, expected %b",
                                 checked, got.alarm_sounding, want.alarm_sounding));
        endtask

    endclass

endpackage

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: top-level bench for alarm_priority_beep_pattern
// Sends directed and random tick and mute beats with random gaps and result
// stalls, rewrites the mute timeout and guard limit between phases, and
// checks every result beat against the scoreboard's prediction.
// ---------------------------------------------------------------------------
module testbench;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BEATS    = 132;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        operation;
    logic        mute_value;
    logic [6:0]  battery_level;
    logic        charging;
    logic        battery_low;
    logic        tank_full;
    logic        leak_found;
    logic        block_found;
    logic        out_valid;
    logic        out_ready;
    logic        buzzer_on;
    logic        white_led_on;
    logic [2:0]  alarm_code;
    logic        muted;
    logic        alarm_sounding;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    alarm_tb_pkg::alarm_scoreboard board;
    bit              sender_steady;
    bit              receiver_steady;
    int              idle_cycles;

    alarm_priority_beep_pattern dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .mute_value     (mute_value),
        .battery_level  (battery_level),
        .charging       (charging),
        .battery_low    (battery_low),
        .tank_full      (tank_full),
        .leak_found     (leak_found),
        .block_found    (block_found),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .buzzer_on      (buzzer_on),
        .white_led_on   (white_led_on),
        .alarm_code     (alarm_code),
        .muted          (muted),
        .alarm_sounding (alarm_sounding),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // The run ends if nothing moves on any port for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: stall at random, then check each accepted beat.
    initial
    begin
        int                          stall;
        alarm_tb_pkg::alarm_result_t got;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 29) == 0)
                receiver_steady = !receiver_steady;
            stall = receiver_steady ? 0 : $urandom_range(0, 19);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            got.buzzer_on      = buzzer_on;
            got.white_led_on   = white_led_on;
            got.alarm_code     = apbp_pkg::alarm_code_t'(alarm_code);
            got.muted          = muted;
            got.alarm_sounding = alarm_sounding;
            board.check_result(got);
        end
    end

    // Send one input beat after a random gap and wait until it is taken.
    task automatic send_beat(input alarm_tb_pkg::tick_beat_t b);
        int gap;
        if ($urandom_range(0, 29) == 0)
            sender_steady = !sender_steady;
        gap = sender_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        {operation, mute_value, battery_level, charging, battery_low,
         tank_full, leak_found, block_found} <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_beat(b);
    endtask

    // Hold off the sender until every predicted result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    // APB write: setup cycle, access cycle, then psel is dropped.
    task automatic write_register(input logic index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        board.set_register(index, value);
        @(posedge clk);
    endtask

    function automatic alarm_tb_pkg::tick_beat_t make_beat(logic op, logic mv,
                                                           logic [6:0] level,
                                                           logic chg, logic low,
                                                           logic full, logic leak,
                                                           logic blk);
        return '{op, mv, level, chg, low, full, leak, blk};
    endfunction

    // Random tick beat whose flags select the wanted alarm.
    function automatic alarm_tb_pkg::tick_beat_t alarm_beat(apbp_pkg::alarm_code_t want);
        alarm_tb_pkg::tick_beat_t b;
        logic [31:0]              raw;
        raw = $urandom;
        b = raw[$bits(alarm_tb_pkg::tick_beat_t)-1:0];
        b.operation = alarm_tb_pkg::OP_TICK;
        case (want)
            apbp_pkg::ALARM_CRITICAL:
            begin
                b.battery_level = '0;
                b.charging = 1'b0;
            end
            apbp_pkg::ALARM_FULL:
                b.tank_full = 1'b1;
            apbp_pkg::ALARM_LEAK:
            begin
                b.tank_full = 1'b0;
                b.leak_found = 1'b1;
            end
            apbp_pkg::ALARM_BLOCK:
            begin
                b.tank_full = 1'b0;
                b.leak_found = 1'b0;
                b.block_found = 1'b1;
            end
            apbp_pkg::ALARM_LOW:
            begin
                b.tank_full = 1'b0;
                b.leak_found = 1'b0;
                b.block_found = 1'b0;
                b.battery_low = 1'b1;
                b.charging = 1'b0;
            end
            default:
            begin
                b.tank_full = 1'b0;
                b.leak_found = 1'b0;
                b.block_found = 1'b0;
                if (!b.charging)
                    b.battery_low = 1'b0;
            end
        endcase
        // Keep clear of the critical alarm unless it is the one wanted.
        if (want != apbp_pkg::ALARM_CRITICAL && b.battery_level == '0 && !b.charging)
            b.battery_level = 7'($urandom_range(1, 127));
        return b;
    endfunction

    // Fully random beat of the given operation.
    function automatic alarm_tb_pkg::tick_beat_t noise_beat(logic op);
        alarm_tb_pkg::tick_beat_t b;
        logic [31:0]              raw;
        raw = $urandom;
        b = raw[$bits(alarm_tb_pkg::tick_beat_t)-1:0];
        b.operation = op;
        return b;
    endfunction

    // Runs of one alarm with random content, some mute commands and noise.
    task automatic run_random_phase(input int beat_count);
        int                    sent;
        int                    run_left;
        int                    pick;
        apbp_pkg::alarm_code_t target;
        sent = 0;
        run_left = 0;
        target = apbp_pkg::ALARM_NONE;
        while (sent < beat_count)
        begin
            if (run_left == 0)
            begin
                target = apbp_pkg::alarm_code_t'($urandom_range(0, 5));
                run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 160)
                                                       : $urandom_range(1, 40);
            end
            pick = $urandom_range(0, 99);
            if (pick < 4)
                send_beat(noise_beat(alarm_tb_pkg::OP_SET_MUTE));
            else if (pick < 9)
                send_beat(noise_beat(alarm_tb_pkg::OP_TICK));
            else
                send_beat(alarm_beat(target));
            run_left--;
            sent++;
            if (sent == beat_count / 2)
                drain_results();
        end
    endtask

    initial
    begin
        board          = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        operation      = alarm_tb_pkg::OP_TICK;
        mute_value     = 1'b0;
        battery_level  = '0;
        charging       = 1'b0;
        battery_low    = 1'b0;
        tank_full      = 1'b0;
        leak_found     = 1'b0;
        block_found    = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        idle_cycles    = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: priority order, charger masking, field extremes and mute.
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd100,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd0,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd0,
                            1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd127,
                            1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd64,
                            1'b0, 1'b0, 1'b1, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd1,
                            1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd50,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b1, 7'd0,
                            1'b0, 1'b1, 1'b1, 1'b1, 1'b1));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd0,
                            1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd99,
                            1'b0, 1'b1, 1'b0, 1'b1, 1'b1));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd31,
                            1'b0, 1'b1, 1'b0, 1'b0, 1'b1));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd12,
                            1'b1, 1'b1, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_SET_MUTE, 1'b1, 7'd127,
                            1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd80,
                            1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd80,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_SET_MUTE, 1'b0, 7'd0,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd80,
                            1'b0, 1'b0, 1'b0, 1'b1, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_SET_MUTE, 1'b0, 7'd5,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_SET_MUTE, 1'b1, 7'd0,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_TICK, 1'b0, 7'd0,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
        send_beat(make_beat(alarm_tb_pkg::OP_SET_MUTE, 1'b0, 7'd0,
                            1'b0, 1'b0, 1'b0, 1'b0, 1'b0));

        // Random phases, each under its own mute timeout and guard limit.
        run_random_phase(PHASE_BEATS);

        drain_results();
        write_register(apbp_pkg::CFG_IDX_MUTE_LIMIT, 32'd0);
        write_register(apbp_pkg::CFG_IDX_BEEPER_MAX, 32'd0);
        run_random_phase(PHASE_BEATS);

        drain_results();
        write_register(apbp_pkg::CFG_IDX_MUTE_LIMIT, 32'd65535);
        write_register(apbp_pkg::CFG_IDX_BEEPER_MAX, 32'd1000);
        run_random_phase(PHASE_BEATS);

        drain_results();
        write_register(apbp_pkg::CFG_IDX_MUTE_LIMIT, 32'd9);
        write_register(apbp_pkg::CFG_IDX_BEEPER_MAX, 32'd1);
        run_random_phase(PHASE_BEATS);

        drain_results();
        repeat (4) @(posedge clk);
        if (board.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
